// ----- rtl/vqnca_pkg.sv -----
// ----------------------------------------------------------------------------
// vqnca_pkg: shared types and constants
// Sizes, input kinds, register indexes and the distance token that moves
// along the cell chain.
// ----------------------------------------------------------------------------
package vqnca_pkg;

    localparam int CB_MAX     = 256;
    localparam int DIM_MAX    = 16;
    localparam int ELEM_BITS  = 16;

    localparam int IDX_W      = $clog2(CB_MAX);
    localparam int SIZE_W     = $clog2(CB_MAX + 1);
    localparam int ELEM_IDX_W = $clog2(DIM_MAX);
    localparam int DIM_W      = 5;
    localparam int DIST_W     = 31;
    localparam int DIFF_W     = ELEM_BITS + 1;
    localparam int SQ_W       = 2 * ELEM_BITS;

    localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

    // input word kinds
    localparam logic [1:0] KIND_CW  = 2'd0;
    localparam logic [1:0] KIND_PT  = 2'd1;
    localparam logic [1:0] KIND_NEW = 2'd2;

    // register indexes
    localparam logic REG_DIMENSION     = 1'b0;
    localparam logic REG_CODEBOOK_SIZE = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] sum;
    } token_t;

endpackage

// ----- rtl/vq_nearest_codeword_assign.sv -----
// ----------------------------------------------------------------------------
// vq_nearest_codeword_assign: nearest-codeword search of a vector quantizer
// Search: a point's last element starts one; the sweep issues one codeword
//   a cycle into a chain of DIM_MAX cells (token registers tok_a, tok_b and
//   tok_c each), then a compare, a utility read and a utility write that
//   waits on out_stall. Codeword, pass and non-final point words are taken
//   while idle; the input stalls during a search, set by sweep and chain.
// Reset: async active low; utilities, error sum, previous winner cleared
//   (utilities through valid bits), dimension 4, codebook_size 16.
// ----------------------------------------------------------------------------
module vq_nearest_codeword_assign (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             kind,
    input  logic [vqnca_pkg::IDX_W-1:0]            entry_index,
    input  logic [vqnca_pkg::ELEM_IDX_W-1:0]       element_index,
    input  logic signed [vqnca_pkg::ELEM_BITS-1:0] sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [vqnca_pkg::IDX_W-1:0]            nearest_index,
    output logic [vqnca_pkg::DIST_W-1:0]           best_distance,
    output logic [vqnca_pkg::DIST_W-1:0]           codeword_utility,
    output logic [vqnca_pkg::DIST_W-1:0]           total_error,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic                                   cfg_index,
    input  logic [8:0]                             cfg_data
);
    import vqnca_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SWEEP = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_URD   = 5'b01000,
        ST_UWR   = 5'b10000
    } state_t;

    state_t             state_reg;
    state_t             state_next;

    logic [DIM_W-1:0]   dim_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [DIM_W-1:0]   dim_eff;
    logic [SIZE_W-1:0]  size_eff;

    logic               in_acc;
    logic               pt_last;
    logic [SIZE_W-1:0]  issue_reg;
    logic               issue_last;
    logic [IDX_W-1:0]   prev_reg;
    logic [IDX_W-1:0]   pref_idx;

    token_t             chain [DIM_MAX+1];
    logic [DIM_MAX-1:0] cw_wr;
    logic [DIM_MAX-1:0] pt_wr;
    logic [DIM_MAX-1:0] active;

    logic [IDX_W-1:0]   win_idx;
    logic [DIST_W-1:0]  win_dist;
    logic               srch_done;

    // utility store: memory plus one valid bit per entry (cleared => zero)
    logic [DIST_W-1:0]  util_mem [CB_MAX];
    logic [CB_MAX-1:0]  util_vld_reg;
    logic [DIST_W-1:0]  util_rd_reg;
    logic               vld_rd_reg;
    logic [DIST_W-1:0]  util_cur;
    logic [DIST_W:0]    util_wide;
    logic [DIST_W-1:0]  util_new;
    logic [DIST_W:0]    err_wide;
    logic [DIST_W-1:0]  err_new;
    logic [DIST_W-1:0]  err_reg;
    logic               out_free;
    logic               commit;

    logic               out_valid_reg;
    logic [IDX_W-1:0]   nearest_reg;
    logic [DIST_W-1:0]  best_out_reg;
    logic [DIST_W-1:0]  util_out_reg;
    logic [DIST_W-1:0]  err_out_reg;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg  <= DIM_W'(4);
            size_reg <= SIZE_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DIMENSION:     dim_reg  <= cfg_data[DIM_W-1:0];
                REG_CODEBOOK_SIZE: size_reg <= cfg_data[SIZE_W-1:0];
                default:           ;
            endcase
        end
    end

    // out-of-range settings clamp into 1..max
    always_comb
    begin
        if (dim_reg == '0)
            dim_eff = DIM_W'(1);
        else if (dim_reg > DIM_W'(DIM_MAX))
            dim_eff = DIM_W'(DIM_MAX);
        else
            dim_eff = dim_reg;
        if (size_reg == '0)
            size_eff = SIZE_W'(1);
        else if (size_reg > SIZE_W'(CB_MAX))
            size_eff = SIZE_W'(CB_MAX);
        else
            size_eff = size_reg;
    end

    // ---------------- input side ----------------
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign pt_last  = in_acc && (kind == KIND_PT) &&
                      ({1'b0, element_index} == (dim_eff - DIM_W'(1)));

    // a stale previous winner gets no preference: index 0 is then first anyway
    assign pref_idx = ({1'b0, prev_reg} < size_eff) ? prev_reg : '0;

    // ---------------- cell chain ----------------
    assign issue_last = (issue_reg == (size_eff - SIZE_W'(1)));

    assign chain[0].valid = (state_reg == ST_SWEEP);
    assign chain[0].last  = issue_last;
    assign chain[0].idx   = issue_reg[IDX_W-1:0];
    assign chain[0].sum   = '0;

    for (genvar j = 0; j < DIM_MAX; j++)
    begin : g_cell
        assign cw_wr[j]  = in_acc && (kind == KIND_CW) &&
                           (element_index == ELEM_IDX_W'(j));
        assign pt_wr[j]  = in_acc && (kind == KIND_PT) &&
                           (element_index == ELEM_IDX_W'(j));
        assign active[j] = (DIM_W'(j) < dim_eff);

        vqnca_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (cw_wr[j]),
            .wr_addr (entry_index),
            .wr_data (sample),
            .pt_en   (pt_wr[j]),
            .pt_data (sample),
            .active  (active[j]),
            .tok_in  (chain[j]),
            .tok_out (chain[j+1])
        );
    end

    vqnca_min_track u_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pt_last),
        .pref_idx  (pref_idx),
        .tok       (chain[DIM_MAX]),
        .win_idx   (win_idx),
        .win_dist  (win_dist),
        .done      (srch_done)
    );

    // ---------------- sequencer ----------------
    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = (state_reg == ST_UWR) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (pt_last) state_next = ST_SWEEP;
            ST_SWEEP: if (issue_last) state_next = ST_WAIT;
            ST_WAIT:  if (srch_done) state_next = ST_URD;
            ST_URD:   state_next = ST_UWR;
            ST_UWR:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            issue_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SWEEP)
                issue_reg <= issue_reg + SIZE_W'(1);
            else
                issue_reg <= '0;
        end
    end

    // ---------------- utility and error update ----------------
    always_ff @(posedge clk)
    begin
        util_rd_reg <= util_mem[win_idx];
        vld_rd_reg  <= util_vld_reg[win_idx];
        if (commit)
        begin
            util_mem[win_idx] <= util_new;
        end
    end

    always_comb
    begin
        util_cur  = vld_rd_reg ? util_rd_reg : '0;
        util_wide = {1'b0, util_cur} + {1'b0, win_dist};
        util_new  = util_wide[DIST_W] ? DIST_SAT : util_wide[DIST_W-1:0];
        err_wide  = {1'b0, err_reg} + {1'b0, win_dist};
        err_new   = err_wide[DIST_W] ? DIST_SAT : err_wide[DIST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            util_vld_reg  <= '0;
            err_reg       <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc && (kind == KIND_NEW))
            begin
                util_vld_reg <= '0;
                err_reg      <= '0;
            end
            else if (commit)
            begin
                util_vld_reg[win_idx] <= 1'b1;
                err_reg               <= err_new;
                prev_reg              <= win_idx;
            end
            if (commit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            nearest_reg  <= win_idx;
            best_out_reg <= win_dist;
            util_out_reg <= util_new;
            err_out_reg  <= err_new;
        end
    end

    assign out_valid        = out_valid_reg;
    assign nearest_index    = nearest_reg;
    assign best_distance    = best_out_reg;
    assign codeword_utility = util_out_reg;
    assign total_error      = err_out_reg;

    // ---------------- checks ----------------
    a_tok_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        chain[DIM_MAX].valid |-> (state_reg == ST_SWEEP || state_reg == ST_WAIT))
        else $error("distance token outside a search");

    a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_UWR))
        else $error("result word without utility commit");

    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("commit did not return to idle with a result");

endmodule

// ----- rtl/vqnca_cell.sv -----
// ----------------------------------------------------------------------------
// vqnca_cell: one element position of the distance chain
// Holds one point element and that element of every codeword; adds its
// squared difference to the passing token, saturating.
// ----------------------------------------------------------------------------
module vqnca_cell (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     wr_en,
    input  logic [vqnca_pkg::IDX_W-1:0]              wr_addr,
    input  logic signed [vqnca_pkg::ELEM_BITS-1:0]   wr_data,
    input  logic                                     pt_en,
    input  logic signed [vqnca_pkg::ELEM_BITS-1:0]   pt_data,
    input  logic                                     active,
    input  vqnca_pkg::token_t                        tok_in,
    output vqnca_pkg::token_t                        tok_out
);
    import vqnca_pkg::*;

    logic signed [ELEM_BITS-1:0] mem [CB_MAX];
    logic signed [ELEM_BITS-1:0] rd_data_reg;
    logic signed [ELEM_BITS-1:0] pt_reg;
    token_t                      tok_a_reg;
    token_t                      tok_b_reg;
    token_t                      tok_c_reg;
    logic [SQ_W-1:0]             sq_reg;
    logic [SQ_W-1:0]             sq_next;
    logic signed [DIFF_W-1:0]    diff;
    logic signed [2*DIFF_W-1:0]  prod;
    logic [DIST_W+1:0]           sum_wide;
    token_t                      tok_c_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[tok_in.idx];
        if (pt_en)
        begin
            pt_reg <= pt_data;
        end
    end

    always_comb
    begin
        diff    = DIFF_W'(pt_reg) - DIFF_W'(rd_data_reg);
        prod    = diff * diff;
        sq_next = active ? prod[SQ_W-1:0] : '0;
    end

    always_comb
    begin
        sum_wide   = {2'b00, tok_b_reg.sum} + {1'b0, sq_reg};
        tok_c_next = tok_b_reg;
        tok_c_next.sum = (sum_wide > {2'b00, DIST_SAT}) ? DIST_SAT : sum_wide[DIST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_a_reg <= '0;
            tok_b_reg <= '0;
            tok_c_reg <= '0;
        end
        else
        begin
            tok_a_reg <= tok_in;
            tok_b_reg <= tok_a_reg;
            tok_c_reg <= tok_c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    assign tok_out = tok_c_reg;

endmodule

// ----- rtl/vqnca_min_track.sv -----
// ----------------------------------------------------------------------------
// vqnca_min_track: running minimum over the chain's output tokens
// Strictly smaller wins; an equal distance wins only for the preferred index.
// ----------------------------------------------------------------------------
module vqnca_min_track (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [vqnca_pkg::IDX_W-1:0]       pref_idx,
    input  vqnca_pkg::token_t                 tok,
    output logic [vqnca_pkg::IDX_W-1:0]       win_idx,
    output logic [vqnca_pkg::DIST_W-1:0]      win_dist,
    output logic                              done
);
    import vqnca_pkg::*;

    logic              first_reg;
    logic              done_reg;
    logic [IDX_W-1:0]  win_idx_reg;
    logic [DIST_W-1:0] best_reg;
    logic              take;

    assign take = tok.valid && (first_reg || (tok.sum < best_reg) ||
                  ((tok.sum == best_reg) && (tok.idx == pref_idx)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= tok.valid && tok.last;
            if (start)
            begin
                first_reg <= 1'b1;
            end
            else if (tok.valid)
            begin
                first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_reg    <= tok.sum;
            win_idx_reg <= tok.idx;
        end
    end

    assign win_idx  = win_idx_reg;
    assign win_dist = best_reg;
    assign done     = done_reg;

endmodule
